// ===== rtl/core/nstp_pkg.sv =====
// shared types and constants for the nmea sentence time parser
`timescale 1ns / 1ps
package nstp_pkg;

    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_A      = 8'h41;
    localparam logic [7:0] C_V      = 8'h56;

    localparam logic [23:0] W_GSV = 24'h475356;
    localparam logic [23:0] W_RMC = 24'h524D43;
    localparam logic [23:0] W_GGA = 24'h474741;
    localparam logic [23:0] W_GLL = 24'h474C4C;

    localparam logic [2:0] K_OTHER = 3'd0;
    localparam logic [2:0] K_GSV   = 3'd1;
    localparam logic [2:0] K_RMC   = 3'd2;
    localparam logic [2:0] K_GGA   = 3'd3;
    localparam logic [2:0] K_GLL   = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_CKSUM  = 3'd1;
    localparam logic [2:0] ST_KIND   = 3'd2;
    localparam logic [2:0] ST_LETTER = 3'd3;
    localparam logic [2:0] ST_TIME   = 3'd4;
    localparam logic [2:0] ST_DATE   = 3'd5;
    localparam logic [2:0] ST_DIGIT  = 3'd6;

    localparam logic [11:0] YEAR_BASE = 12'd2000;
    localparam logic [11:0] MIN_YEAR_RST = 12'd2019;

    // character class decided by the front end
    typedef enum logic [1:0] {
        OP_SKIP  = 2'd0,
        OP_START = 2'd1,
        OP_END   = 2'd2,
        OP_CHAR  = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic       is_dig;
        logic [3:0] dig;
        logic       is_hex;
        logic [3:0] hex;
    } t_cmd;

endpackage

// ===== rtl/core/nstp_front.sv =====
// byte intake and classification
`timescale 1ns / 1ps
module nstp_front import nstp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cmd       o_cmd
);
    logic r_v;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd.ch     = i_byte;
        n_cmd.is_dig = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        n_cmd.dig    = i_byte[3:0];
        n_cmd.is_hex = 1'b1;
        n_cmd.hex    = i_byte[3:0];
        if (n_cmd.is_dig) begin
            n_cmd.hex = i_byte[3:0];
        end else if ((i_byte >= 8'h41 && i_byte <= 8'h46) ||
                     (i_byte >= 8'h61 && i_byte <= 8'h66)) begin
            n_cmd.hex = i_byte[3:0] + 4'd9;
        end else begin
            n_cmd.is_hex = 1'b0;
        end
        if (i_byte == C_DOLLAR) n_cmd.op = OP_START;
        else if (i_byte == C_CR || i_byte == C_LF) n_cmd.op = OP_END;
        else n_cmd.op = OP_CHAR;
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) r_cmd <= n_cmd;
    end
endmodule

// ===== rtl/core/nstp_queue.sv =====
// short queue between classifier and parser
`timescale 1ns / 1ps
module nstp_queue import nstp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_cmd;
    end
endmodule

// ===== rtl/core/nstp_back.sv =====
// sentence parser, checksum and result register
`timescale 1ns / 1ps
module nstp_back import nstp_pkg::*; #(
    parameter int MAX_FIELDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    input  logic [11:0] i_min_year,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [70:0] o_data
);
    localparam int FW = $clog2(MAX_FIELDS);
    localparam logic [FW-1:0] F_LAST = FW'(MAX_FIELDS - 1);

    typedef enum logic [2:0] {
        PH_IDLE, PH_BODY, PH_CK1, PH_CK2, PH_TAIL, PH_CKBAD
    } t_phase;

    t_phase      r_ph;
    logic [7:0]  r_xor, r_sum, r_mode;
    logic [FW-1:0] r_fi;
    logic [4:0]  r_ci;
    logic [23:0] r_kw;
    logic [6:0]  r_hh, r_mm, r_ss, r_dd, r_mo, r_yy, r_sa, r_sl;
    logic [9:0]  r_ms;
    logic        r_de;
    logic        r_ov;
    logic [70:0] r_out;

    logic       w_take;
    logic [2:0] w_k;
    logic [FW-1:0] w_tf;
    logic       w_has_tf;
    logic [7:0] c;
    logic       dg;
    logic [3:0] d;

    function automatic logic [6:0] add7(input logic [6:0] a, input logic [3:0] v);
        add7 = 7'((a << 3) + (a << 1) + {3'd0, v});
    endfunction

    assign o_ready = !r_ov || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign c  = i_cmd.ch;
    assign dg = i_cmd.is_dig;
    assign d  = i_cmd.dig;

    always_comb begin
        if (r_kw == W_GSV) w_k = K_GSV;
        else if (r_kw == W_RMC) w_k = K_RMC;
        else if (r_kw == W_GGA) w_k = K_GGA;
        else if (r_kw == W_GLL) w_k = K_GLL;
        else w_k = K_OTHER;
        w_has_tf = (w_k == K_RMC) || (w_k == K_GGA) || (w_k == K_GLL);
        w_tf = (w_k == K_GLL) ? FW'(5) : FW'(1);
    end

    // per-field predicates
    logic in_tf, in_date, in_mode, in_sat;
    assign in_tf   = w_has_tf && r_fi == w_tf;
    assign in_date = w_k == K_RMC && r_fi == FW'(9);
    assign in_mode = (w_k == K_RMC && r_fi == FW'(2)) || (w_k == K_GLL && r_fi == FW'(6));
    assign in_sat  = w_k == K_GSV && r_fi == FW'(3);

    logic fin_err;
    assign fin_err = r_fi != '0 &&
        ((in_tf && r_ci < 5'd6) || (in_date && r_ci < 5'd6) ||
         (in_sat && r_ci == 5'd0));

    // end of sentence result
    logic [2:0]  e_st;
    logic        e_de, e_ht, e_hd;
    logic [11:0] e_year;
    logic [6:0]  e_sat;
    always_comb begin
        e_st = ST_OK;
        e_de = r_de;
        e_year = YEAR_BASE + {5'd0, r_yy};
        if (w_has_tf && w_tf > r_fi) e_de = 1'b1;
        if (w_k == K_RMC && FW'(9) > r_fi) e_de = 1'b1;
        if (w_k == K_GSV && FW'(3) > r_fi) e_de = 1'b1;
        if (r_ph != PH_TAIL || r_sum != r_xor) e_st = ST_CKSUM;
        else if (w_k == K_OTHER) e_st = ST_KIND;
        else if (w_k == K_RMC && r_mode != C_A && r_mode != C_V) e_st = ST_LETTER;
        else if (w_k == K_GLL && r_mode != C_A) e_st = ST_LETTER;
        else if (e_de) e_st = ST_DIGIT;
        else if (w_has_tf && (r_hh > 7'd23 || r_mm > 7'd59 || r_ss > 7'd59)) e_st = ST_TIME;
        else if (w_k == K_RMC && (r_dd < 7'd1 || r_dd > 7'd31 || r_mo < 7'd1 ||
                 r_mo > 7'd12 || e_year < i_min_year)) e_st = ST_DATE;
        e_ht = e_st != ST_CKSUM && w_has_tf &&
               (e_st == ST_OK || e_st == ST_TIME || e_st == ST_DATE);
        e_hd = e_st != ST_CKSUM && w_k == K_RMC && (e_st == ST_OK || e_st == ST_DATE);
        e_sat = (e_st == ST_OK && w_k == K_GSV) ? r_sa : r_sl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
            r_ov <= 1'b0;
            r_sl <= '0;
            r_xor <= '0; r_sum <= '0; r_mode <= '0; r_fi <= '0; r_ci <= '0;
            r_kw <= '0; r_hh <= '0; r_mm <= '0; r_ss <= '0; r_ms <= '0;
            r_dd <= '0; r_mo <= '0; r_yy <= '0; r_sa <= '0; r_de <= 1'b0;
        end else begin
            if (w_take && i_cmd.op == OP_END && r_ph != PH_IDLE) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (w_take) begin
                case (i_cmd.op)
                    OP_START: begin
                        r_ph <= PH_BODY;
                        r_xor <= '0; r_sum <= '0; r_mode <= '0; r_fi <= '0; r_ci <= '0;
                        r_kw <= '0; r_hh <= '0; r_mm <= '0; r_ss <= '0; r_ms <= '0;
                        r_dd <= '0; r_mo <= '0; r_yy <= '0; r_sa <= '0; r_de <= 1'b0;
                    end
                    OP_END: begin
                        if (r_ph != PH_IDLE) begin
                            r_ph <= PH_IDLE;
                            r_sl <= e_sat;
                            r_out <= {e_sat, e_hd,
                                      e_hd ? e_year : 12'd0,
                                      e_hd ? r_mo : 7'd0,
                                      e_hd ? r_dd : 7'd0,
                                      (e_ht && w_k == K_GGA) ? r_ms : 10'd0,
                                      e_ht ? r_ss : 7'd0,
                                      e_ht ? r_mm : 7'd0,
                                      e_ht ? r_hh : 7'd0,
                                      (e_st == ST_CKSUM) ? K_OTHER : w_k,
                                      e_st};
                        end
                    end
                    OP_CHAR: begin
                        case (r_ph)
                            PH_BODY: begin
                                if (c == C_STAR) begin
                                    if (r_fi == '0 && r_ci != 5'd5) r_kw <= '0;
                                    if (fin_err) r_de <= 1'b1;
                                    r_ph <= PH_CK1;
                                end else begin
                                    r_xor <= r_xor ^ c;
                                    if (c == C_COMMA && r_fi == '0 && r_ci != 5'd5)
                                        r_kw <= '0;
                                    if (c == C_COMMA && r_fi != F_LAST) begin
                                        if (fin_err) r_de <= 1'b1;
                                        r_fi <= r_fi + 1'b1;
                                        r_ci <= '0;
                                    end else begin
                                        // a comma in the last field opens no new field; it counts as a field
                                        // character and is flagged only where that field is one of the checked fields
                                        if (r_ci != 5'd31) r_ci <= r_ci + 1'b1;
                                        if (r_fi == '0) begin
                                            r_kw <= {r_kw[15:0], c};
                                        end else if (in_tf) begin
                                            if (r_ci < 5'd6 || (w_k == K_GGA &&
                                                r_ci >= 5'd7 && r_ci <= 5'd9)) begin
                                                if (!dg) r_de <= 1'b1;
                                                else if (r_ci < 5'd2) r_hh <= add7(r_hh, d);
                                                else if (r_ci < 5'd4) r_mm <= add7(r_mm, d);
                                                else if (r_ci < 5'd6) r_ss <= add7(r_ss, d);
                                                else r_ms <= 10'((r_ms << 3) + (r_ms << 1)
                                                             + {6'd0, d});
                                            end
                                        end else if (in_date) begin
                                            if (r_ci < 5'd6) begin
                                                if (!dg) r_de <= 1'b1;
                                                else if (r_ci < 5'd2) r_dd <= add7(r_dd, d);
                                                else if (r_ci < 5'd4) r_mo <= add7(r_mo, d);
                                                else r_yy <= add7(r_yy, d);
                                            end
                                        end else if (in_mode) begin
                                            if (r_ci == 5'd0) r_mode <= c;
                                        end else if (in_sat) begin
                                            if (!dg) r_de <= 1'b1;
                                            else if (r_sa > 7'd9) r_sa <= 7'd99;
                                            else if (add7(r_sa, d) > 7'd99) r_sa <= 7'd99;
                                            else r_sa <= add7(r_sa, d);
                                        end
                                    end
                                end
                            end
                            PH_CK1, PH_CK2: begin
                                if (!i_cmd.is_hex) r_ph <= PH_CKBAD;
                                else begin
                                    r_sum <= {r_sum[3:0], i_cmd.hex};
                                    r_ph <= (r_ph == PH_CK1) ? PH_CK2 : PH_TAIL;
                                end
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== rtl/core/nmea_sentence_time_parser_core.sv =====
// top level of the nmea sentence time parser
// path: each byte passes the classifier register, the queue and the parser in turn (classify, queue, parse)
// throughput: one byte per cycle while m_axis_tready does not stall the result; one result beat per sentence end
// reset: synchronous active low, clears parser phase and counts, sets min_year to 2019
// min_year is held in a register written over the apb port
`timescale 1ns / 1ps
module nmea_sentence_time_parser_core import nstp_pkg::*; #(
    parameter int MAX_FIELDS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, sentence_kind, hour, minute, second, millisecond, day, month,
    // year, date_present, sat_count; zero filled
    output logic [71:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [11:0] r_min_year;
    logic        w_fv, w_fr, w_qv, w_qr;
    t_cmd        w_fc, w_qc;
    logic [70:0] w_out;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {20'd0, r_min_year} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RST;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_min_year <= pwdata[11:0];
        end
    end

    nstp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_byte(s_axis_tdata),
        .o_valid(w_fv), .i_ready(w_fr), .o_cmd(w_fc)
    );

    nstp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fv), .o_ready(w_fr), .i_cmd(w_fc),
        .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_qc)
    );

    nstp_back #(.MAX_FIELDS(MAX_FIELDS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_cmd(w_qc),
        .i_min_year(r_min_year),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_out)
    );

    assign m_axis_tdata = {1'b0, w_out};
endmodule
